@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Block table sizing, status and operation codes, cell interface structs.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MaxBlocks   = 16;
  localparam int HeaderBytes = 16;
  localparam int AddrWidth   = 32;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;
  localparam logic [1:0] OP_CALLOC  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [0:0] REG_BASE  = 1'd0;
  localparam logic [0:0] REG_LIMIT = 1'd1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic            fit_found;
    logic [IdxW-1:0] fit_idx;
    logic [31:0]     fit_off;
    logic            match_found;
    logic [IdxW-1:0] match_idx;
    logic [31:0]     match_len;
    logic [31:0]     match_off;
  } scan_t;

  // table write command broadcast to all cells
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] idx;
    logic            set_off;
    logic [31:0]     off;
    logic [31:0]     len;
    logic            is_free;
    logic            rel_we;
    logic [IdxW-1:0] rel_idx;
  } cell_wr_t;

  // payload address of an entry offset
  function automatic logic [31:0] paddr(logic [31:0] base, logic [31:0] off);
    logic [AddrWidth-1:0] s;
    s = AddrWidth'(base) + AddrWidth'(off);
    return 32'(s);
  endfunction

endpackage

@@ rtl/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// ffha_cell: one table entry of the allocator
// Holds offset, length and free mark; merges its match into the search token.
// ----------------------------------------------------------------------------
module ffha_cell
  import ffha_pkg::*;
(
  input  logic            clk,
  input  logic [IdxW-1:0] my_idx,
  input  logic [CntW-1:0] count,
  input  logic [31:0]     base,
  input  logic [31:0]     req_addr,
  input  logic [32:0]     req_size,
  input  cell_wr_t        wr,
  input  scan_t           scan_in,
  output scan_t           scan_out
);

  logic [31:0] offset;
  logic [31:0] length;
  logic        is_free;
  logic        live;

  // entry storage; the free-mark port targets a different entry than the main one
  always_ff @(posedge clk) begin
    if (wr.we && wr.idx == my_idx) begin
      if (wr.set_off) begin
        offset <= wr.off;
        length <= wr.len;
      end
      is_free <= wr.is_free;
    end else if (wr.rel_we && wr.rel_idx == my_idx) begin
      is_free <= 1'b1;
    end
  end

  // lowest index wins, so earlier cells keep priority
  always_comb begin
    live     = CntW'(my_idx) < count;
    scan_out = scan_in;
    if (!scan_in.fit_found && live && is_free && {1'b0, length} >= req_size) begin
      scan_out.fit_found = 1'b1;
      scan_out.fit_idx   = my_idx;
      scan_out.fit_off   = offset;
    end
    if (!scan_in.match_found && live && paddr(base, offset) == req_addr) begin
      scan_out.match_found = 1'b1;
      scan_out.match_idx   = my_idx;
      scan_out.match_len   = length;
      scan_out.match_off   = offset;
    end
  end

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit free-list heap allocator
// The request is captured on acceptance, evaluated in the scan state and
// registered into the output state, where the result is held until taken.
// A new request is accepted only in the idle state, after the previous response
// has been taken; the control sequence sets the pace, plus any output stall.
// Reset clears block count, break offset, and sets heap_limit to 65536.
// Entry storage is not cleared; entries above the count are never used.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: operation[1:0], address[33:2], size[65:34], element_count[97:66]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_address[31:0], status[34:32], copy_source[66:35],
  //        copy_length[98:67], clear_length[130:99]
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  state_t state, state_next;
  logic [31:0] heap_base, heap_limit;
  logic [CntW-1:0] count;
  logic [31:0] brk;

  logic [1:0]  op;
  logic [31:0] addr, sz, cnt;
  logic [32:0] need;
  logic [63:0] prod;
  logic        prod_ovf;

  scan_t       chain [MaxBlocks+1];
  cell_wr_t    wr;
  logic [31:0] res, csrc, clen, zlen;
  logic [2:0]  st;
  logic [CntW-1:0] count_next;
  logic [31:0] brk_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= 32'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE:  heap_base  <= cfg_data;
        REG_LIMIT: heap_limit <= cfg_data;
        default:   ;
      endcase
    end
  end

  // request capture and product register
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op   <= s_axis_tdata[1:0];
      addr <= s_axis_tdata[33:2];
      sz   <= s_axis_tdata[65:34];
      cnt  <= s_axis_tdata[97:66];
      prod <= 64'(s_axis_tdata[65:34]) * 64'(s_axis_tdata[97:66]);
    end
  end

  assign prod_ovf = |prod[63:32];
  assign need     = (op == OP_CALLOC) ? {1'b0, prod[31:0]} : {1'b0, sz};

  // cell chain
  assign chain[0] = '0;
  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    ffha_cell u_cell (
      .clk(clk), .my_idx(IdxW'(g)), .count(count), .base(heap_base),
      .req_addr(addr), .req_size(need), .wr(wr),
      .scan_in(chain[g]), .scan_out(chain[g+1])
    );
  end

  // operation evaluation
  always_comb begin
    scan_t sc;
    logic [33:0] endp;
    logic        do_alloc, do_rel, alloc_ok;
    logic [IdxW-1:0] rel_idx;
    logic [32:0] rel_end;
    sc = chain[MaxBlocks];
    res = '0; csrc = '0; clen = '0; zlen = '0; st = ST_OK;
    wr = '0; count_next = count; brk_next = brk;
    do_alloc = 1'b0; do_rel = 1'b0; alloc_ok = 1'b0;
    rel_idx = sc.match_idx;
    rel_end = '0;
    endp = 34'(brk) + 34'(HeaderBytes) + 34'(need);
    unique case (op)
      OP_ALLOC: do_alloc = 1'b1;
      OP_RELEASE: begin
        if (addr != '0) begin
          if (!sc.match_found) st = ST_UNKNOWN;
          else do_rel = 1'b1;
        end
      end
      OP_RESIZE: begin
        if (addr == '0 || sz == '0) do_alloc = 1'b1;
        else if (!sc.match_found) st = ST_UNKNOWN;
        else if ({1'b0, sc.match_len} >= need) res = addr;
        else do_alloc = 1'b1;
      end
      default: begin
        if (sz == '0 || cnt == '0) st = ST_ZERO;
        else if (prod_ovf) st = ST_OOM;
        else do_alloc = 1'b1;
      end
    endcase
    if (do_alloc) begin
      if (need == '0) st = ST_ZERO;
      else if (sc.fit_found) begin
        alloc_ok = 1'b1;
        wr.we = 1'b1; wr.idx = sc.fit_idx; wr.is_free = 1'b0;
      end else if (count == CntW'(MaxBlocks)) st = ST_FULL;
      else if (endp > 34'(heap_limit)) st = ST_OOM;
      else begin
        alloc_ok = 1'b1;
        wr.we = 1'b1; wr.idx = IdxW'(count); wr.set_off = 1'b1;
        wr.off = brk + 32'(HeaderBytes); wr.len = need[31:0]; wr.is_free = 1'b0;
        count_next = count + 1'b1;
        brk_next = endp[31:0];
      end
      if (alloc_ok) begin
        res = paddr(heap_base, sc.fit_found ? sc.fit_off : brk + 32'(HeaderBytes));
        if (op == OP_CALLOC) zlen = need[31:0];
        if (op == OP_RESIZE && addr != '0 && sz != '0) begin
          csrc = addr; clen = sc.match_len; do_rel = 1'b1;
        end
      end
    end
    // release: resize move frees a slot distinct from the fit slot
    if (do_rel) begin
      rel_end = 33'(sc.match_off) + 33'(sc.match_len);
      if (CntW'(rel_idx) + 1'b1 == count_next && rel_end == {1'b0, brk_next}) begin
        count_next = CntW'(rel_idx);
        brk_next = brk_next - 32'(HeaderBytes) - sc.match_len;
      end else begin
        wr.rel_we = 1'b1; wr.rel_idx = rel_idx;
      end
    end
    // table writes land only in the scan cycle
    if (state != S_SCAN) begin
      wr.we = 1'b0;
      wr.rel_we = 1'b0;
    end
  end

  // result register
  logic [31:0] out_res, out_csrc, out_clen, out_zlen;
  logic [2:0]  out_st;

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      out_res  <= res;
      out_st   <= st;
      out_csrc <= csrc;
      out_clen <= clen;
      out_zlen <= zlen;
    end
  end

  assign m_axis_tdata = {5'd0, out_zlen, out_clen, out_csrc, out_st, out_res};

  // state and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      brk   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        count <= count_next;
        brk   <= brk_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_SCAN;
      S_SCAN: state_next = S_OUT;
      S_OUT:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: first-fit heap allocator request/response check
// Drives allocate, release, resize and zeroed allocate requests over the
// input stream, predicts each response from a local model of the block
// table, and compares responses field by field under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  // first field sits in the high bits, so the address lands in bits [31:0]
  typedef struct packed {
    logic [31:0] zlen;
    logic [31:0] clen;
    logic [31:0] csrc;
    logic [2:0]  status;
    logic [31:0] addr;
  } resp_t;

  // heap model and response queue
  class heap_scoreboard;
    logic [31:0] off_q [MaxBlocks];
    logic [31:0] len_q [MaxBlocks];
    bit          free_q [MaxBlocks];
    int          blocks;
    logic [31:0] brk;
    logic [31:0] base;
    logic [31:0] limit;
    resp_t       pending [$];
    int          errors;
    int          checked;

    function new();
      blocks = 0; brk = 0; base = 0; limit = 32'd65536; errors = 0; checked = 0;
    endfunction

    function logic [31:0] pay(logic [31:0] o);
      return base + o;
    endfunction

    function int lookup(logic [31:0] a);
      for (int i = 0; i < blocks; i++)
        if (pay(off_q[i]) == a) return i;
      return -1;
    endfunction

    function logic [2:0] grab(logic [63:0] sz, output logic [31:0] a);
      logic [63:0] e;
      a = 0;
      if (sz == 0) return ST_ZERO;
      for (int i = 0; i < blocks; i++)
        if (free_q[i] && {32'd0, len_q[i]} >= sz) begin
          free_q[i] = 0;
          a = pay(off_q[i]);
          return ST_OK;
        end
      if (blocks >= MaxBlocks) return ST_FULL;
      e = {32'd0, brk} + HeaderBytes + sz;
      if (e > {32'd0, limit}) return ST_OOM;
      off_q[blocks] = brk + HeaderBytes;
      len_q[blocks] = sz[31:0];
      free_q[blocks] = 0;
      a = pay(off_q[blocks]);
      blocks++;
      brk = e[31:0];
      return ST_OK;
    endfunction

    function void drop(int i);
      logic [63:0] e;
      e = {32'd0, off_q[i]} + len_q[i];
      if (i + 1 == blocks && e == {32'd0, brk}) begin
        blocks = i;
        brk = brk - HeaderBytes - len_q[i];
      end else free_q[i] = 1;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_BASE) base = v; else limit = v;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(logic [1:0] op, logic [31:0] a, logic [31:0] sz,
                               logic [31:0] cnt);
      resp_t r;
      int idx;
      logic [63:0] prod;
      logic [31:0] old;
      r = '0;
      case (op)
        OP_ALLOC: r.status = grab({32'd0, sz}, r.addr);
        OP_RELEASE: begin
          if (a != 0) begin
            idx = lookup(a);
            if (idx < 0) r.status = ST_UNKNOWN; else drop(idx);
          end
        end
        OP_RESIZE: begin
          if (a == 0 || sz == 0) r.status = grab({32'd0, sz}, r.addr);
          else begin
            idx = lookup(a);
            if (idx < 0) r.status = ST_UNKNOWN;
            else if (len_q[idx] >= sz) r.addr = a;
            else begin
              old = len_q[idx];
              r.status = grab({32'd0, sz}, r.addr);
              if (r.status == ST_OK) begin
                r.csrc = a; r.clen = old; drop(idx);
              end
            end
          end
        end
        default: begin
          if (sz == 0 || cnt == 0) r.status = ST_ZERO;
          else begin
            prod = {32'd0, sz} * {32'd0, cnt};
            if (prod > 64'hFFFF_FFFF) r.status = ST_OOM;
            else begin
              r.status = grab(prod, r.addr);
              if (r.status == ST_OK) r.zlen = prod[31:0];
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_response(resp_t got);
      resp_t w;
      checked++;
      if (pending.size() == 0) begin
        report_err("response with nothing pending");
        return;
      end
      w = pending.pop_front();
      if (got.addr != w.addr) report_err($sformatf("address %h want %h", got.addr, w.addr));
      if (got.status != w.status) report_err($sformatf("status %0d want %0d", got.status, w.status));
      if (got.csrc != w.csrc) report_err($sformatf("copy_source %h want %h", got.csrc, w.csrc));
      if (got.clen != w.clen) report_err($sformatf("copy_length %h want %h", got.clen, w.clen));
      if (got.zlen != w.zlen) report_err($sformatf("clear_length %h want %h", got.zlen, w.zlen));
    endfunction

    function void report_err(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [135:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  heap_scoreboard sb;
  int sent;

  first_fit_heap_allocator_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: stalls on its own pattern, sometimes none at all
  int stall_mode;
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata[130:0]);
      case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= ($urandom_range(3) != 0);
        default: m_axis_tready <= ($urandom_range(3) == 0);
      endcase
      if ($urandom_range(60) == 0) stall_mode <= $urandom_range(2);
    end
  end

  task automatic send_req(logic [1:0] op, logic [31:0] a, logic [31:0] sz, logic [31:0] cnt);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, cnt, sz, a, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, a, sz, cnt);
    sent++;
    // bursts with random gaps between them
    if ($urandom_range(4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic idle_wait();
    int guard;
    s_axis_tvalid <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // pick a release/resize address: mostly live ones, sometimes noise
  function automatic logic [31:0] pick_addr();
    int k;
    if (sb.blocks != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(sb.blocks - 1);
      return sb.base + sb.off_q[k];
    end
    return ($urandom_range(1) == 0) ? 32'd0 : $urandom();
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'd0;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [1:0] op;
    logic [31:0] cnt;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(3);
      cnt = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(0, 40);
      if (op == OP_CALLOC) send_req(op, $urandom(), $urandom_range(0, 30), cnt);
      else if ($urandom_range(19) == 0) send_req(op, $urandom(), $urandom(), $urandom());
      else send_req(op, pick_addr(), pick_size(), cnt);
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    stall_mode = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_valid = 0;
    cfg_index = REG_BASE;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero sizes, release of none, unknown address, double release, resize, reuse
    send_req(OP_ALLOC, 0, 0, 0);
    send_req(OP_CALLOC, 0, 0, 5);
    send_req(OP_CALLOC, 0, 7, 0);
    send_req(OP_CALLOC, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_RELEASE, 0, 0, 0);
    send_req(OP_RELEASE, 32'hDEAD_BEEF, 0, 0);
    send_req(OP_ALLOC, 0, 32'hFFFF_FFFF, 0);
    send_req(OP_ALLOC, 0, 100, 0);
    send_req(OP_ALLOC, 0, 50, 0);
    send_req(OP_RESIZE, 32'd16, 80, 0);
    send_req(OP_RESIZE, 32'd16, 0, 0);
    send_req(OP_RESIZE, 32'd16, 300, 0);
    send_req(OP_RESIZE, 0, 20, 0);
    send_req(OP_RESIZE, 32'h1234_5678, 20, 0);
    send_req(OP_RELEASE, 32'd16, 0, 0);
    send_req(OP_RELEASE, 32'd16, 0, 0);
    send_req(OP_CALLOC, 0, 4, 20);
    for (int i = 0; i < 8; i++) send_req(OP_ALLOC, 0, 8, 0);
    idle_wait();

    // phases over several register settings, extremes included
    write_cfg(REG_BASE, 32'hFFFF_FF00);
    write_cfg(REG_LIMIT, 32'hFFFF_FFFF);
    random_phase(150);
    idle_wait();
    write_cfg(REG_LIMIT, 32'd0);
    random_phase(60);
    idle_wait();
    write_cfg(REG_BASE, 32'd0);
    write_cfg(REG_LIMIT, 32'd2000);
    random_phase(200);
    idle_wait();
    write_cfg(REG_BASE, $urandom());
    write_cfg(REG_LIMIT, 32'd65536);
    random_phase(220);
    idle_wait();
    write_cfg(REG_BASE, 32'hFFFF_FFFF);
    write_cfg(REG_LIMIT, $urandom());
    random_phase(200);
    idle_wait();

    $display("%0d requests sent, %0d responses checked across six register settings",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending.size());
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end
endmodule

@@ files.f @@
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/first_fit_heap_allocator_unit.sv
test/testbench.sv
